### rtl/two_level_page_table_engine_top_assert.svh
// ----------------------------------------------------------------------------
// Page table engine assertion macros
// Shared concurrent-check forms for the page table engine.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define TLPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TLPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// Page table engine package
// Opcodes, status codes and sizing constants of the page table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlpt_pkg;

   localparam int DIR_ENTRIES_DEFAULT = 16;
   localparam int TABLE_ENTRIES       = 1024;
   localparam int IDX_WIDTH           = 10;
   localparam int OFFSET_WIDTH        = 12;
   localparam int WORD_WIDTH          = 32;
   localparam int REQ_DATA_WIDTH      = 80;
   localparam int REQ_USER_WIDTH      = 2;
   localparam int RSP_DATA_WIDTH      = 32;
   localparam int RSP_USER_WIDTH      = 2;

   typedef logic [1:0] opcode_type;
   typedef logic [1:0] status_type;

   localparam opcode_type OP_TRANSLATE = 2'd0;
   localparam opcode_type OP_MAP       = 2'd1;
   localparam opcode_type OP_UNMAP     = 2'd2;
   localparam opcode_type OP_SET_DIR   = 2'd3;

   localparam status_type ST_OK          = 2'd0;
   localparam status_type ST_DIR_ABSENT  = 2'd1;
   localparam status_type ST_PAGE_ABSENT = 2'd2;

   localparam logic [WORD_WIDTH-1:0] ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [WORD_WIDTH-1:0] PTE_PRESENT = 32'h0000_0001;

endpackage

### rtl/tlpt_ram.sv
// ----------------------------------------------------------------------------
// Page table engine RAM
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/two_level_page_table_engine_top.sv
// An accepted request enters the busy state; its result is registered onto rsp
//    once that state ends, held while a response waits. A new request is taken
//    only when idle; the entry RAM is read, then map and unmap write it back.
// Reset: synchronous; afterwards a clearing pass zeroes the DIR_ENTRIES * 1024
//    entries of the entry RAM and the directory RAM; req_tready stays low.
// ----------------------------------------------------------------------------
// Two-level page table engine
// Translate, map, unmap and directory-present requests on a 10/10/12 split.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "two_level_page_table_engine_top_assert.svh"

module two_level_page_table_engine_top #(
   parameter int DIR_ENTRIES = tlpt_pkg::DIR_ENTRIES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // virt_addr[31:0], phys_addr[63:32], entry_flags[75:64],
   // dir_present_value[76], zero[79:77]
   input  logic [tlpt_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // opcode[1:0]
   input  logic [tlpt_pkg::REQ_USER_WIDTH-1:0]   req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // result_word[31:0]
   output logic [tlpt_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // status[1:0]
   output logic [tlpt_pkg::RSP_USER_WIDTH-1:0]   rsp_tuser
);

   import tlpt_pkg::*;

   localparam int TDEPTH = DIR_ENTRIES * TABLE_ENTRIES;
   localparam int TAW    = $clog2(TDEPTH);
   localparam int DAW    = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
   localparam logic [IDX_WIDTH:0] DIR_LIMIT = (IDX_WIDTH + 1)'(DIR_ENTRIES);
   localparam logic [TAW-1:0]     CLR_LAST  = TAW'(TDEPTH - 1);
   localparam logic [TAW-1:0]     CLR_DIRS  = TAW'(DIR_ENTRIES);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_BUSY  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [TAW-1:0] clr_cnt_ff, clr_cnt_in;

   logic [WORD_WIDTH-1:0]   virt_addr;
   logic [WORD_WIDTH-1:0]   phys_addr;
   logic [OFFSET_WIDTH-1:0] entry_flags;
   logic                    dir_present_value;
   opcode_type              opcode;
   logic [IDX_WIDTH-1:0]    dir_idx;
   logic [IDX_WIDTH-1:0]    tab_idx;
   logic                    req_fire;

   opcode_type              op_ff;
   logic [OFFSET_WIDTH-1:0] off_ff;
   logic [WORD_WIDTH-1:0]   new_entry_ff;
   logic                    dp_ff;
   logic                    in_range_ff;
   logic [TAW-1:0]          tbl_addr_ff;
   logic [DAW-1:0]          dir_addr_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0]   rsp_word_ff, rsp_word_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic                    tbl_we, dir_we;
   logic [TAW-1:0]          tbl_waddr;
   logic [DAW-1:0]          dir_waddr;
   logic [WORD_WIDTH-1:0]   tbl_wdata;
   logic                    dir_wdata;
   logic [WORD_WIDTH-1:0]   old_entry;
   logic                    dir_bit;
   logic                    dir_ok;
   logic                    finish;

   assign virt_addr         = req_tdata[31:0];
   assign phys_addr         = req_tdata[63:32];
   assign entry_flags       = req_tdata[75:64];
   assign dir_present_value = req_tdata[76];
   assign opcode            = req_tuser;
   assign dir_idx           = virt_addr[31:22];
   assign tab_idx           = virt_addr[21:12];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign finish     = (state_ff == S_BUSY) && (!rsp_valid_ff || rsp_tready);
   assign dir_ok     = in_range_ff && dir_bit;

   tlpt_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (TDEPTH),
      .AW    (TAW)
   ) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .re    (req_fire),
      .raddr (TAW'({dir_idx, tab_idx})),
      .rdata (old_entry)
   );

   tlpt_ram #(
      .WIDTH (1),
      .DEPTH (DIR_ENTRIES),
      .AW    (DAW)
   ) u_dir_ram (
      .clock (clock),
      .we    (dir_we),
      .waddr (dir_waddr),
      .wdata (dir_wdata),
      .re    (req_fire),
      .raddr (DAW'(dir_idx)),
      .rdata (dir_bit)
   );

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      tbl_we        = 1'b0;
      tbl_waddr     = tbl_addr_ff;
      tbl_wdata     = new_entry_ff;
      dir_we        = 1'b0;
      dir_waddr     = dir_addr_ff;
      dir_wdata     = dp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_CLEAR: begin
            tbl_we     = 1'b1;
            tbl_waddr  = clr_cnt_ff;
            tbl_wdata  = '0;
            dir_we     = (clr_cnt_ff < CLR_DIRS);
            dir_waddr  = DAW'(clr_cnt_ff);
            dir_wdata  = 1'b0;
            clr_cnt_in = clr_cnt_ff + TAW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            if (finish) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_word_in   = '0;
               rsp_status_in = ST_OK;
               unique case (op_ff)
                  OP_TRANSLATE: begin
                     if (!dir_ok) begin
                        rsp_status_in = ST_DIR_ABSENT;
                     end else if (!old_entry[0]) begin
                        rsp_status_in = ST_PAGE_ABSENT;
                     end else begin
                        rsp_word_in = {old_entry[31:12], off_ff};
                     end
                  end
                  OP_MAP: begin
                     if (!dir_ok) begin
                        rsp_word_in   = ALL_ONES;
                        rsp_status_in = ST_DIR_ABSENT;
                     end else begin
                        rsp_word_in = old_entry;
                        tbl_we      = 1'b1;
                     end
                  end
                  OP_UNMAP: begin
                     if (!dir_ok) begin
                        rsp_status_in = ST_DIR_ABSENT;
                     end else begin
                        rsp_word_in = old_entry;
                        tbl_we      = 1'b1;
                        tbl_wdata   = old_entry & ~PTE_PRESENT;
                     end
                  end
                  OP_SET_DIR: begin
                     if (in_range_ff) begin
                        dir_we = 1'b1;
                     end else begin
                        rsp_status_in = ST_DIR_ABSENT;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      if (req_fire) begin
         op_ff        <= opcode;
         off_ff       <= virt_addr[11:0];
         new_entry_ff <= phys_addr | {20'd0, entry_flags} | PTE_PRESENT;
         dp_ff        <= dir_present_value;
         in_range_ff  <= ({1'b0, dir_idx} < DIR_LIMIT);
         tbl_addr_ff  <= TAW'({dir_idx, tab_idx});
         dir_addr_ff  <= DAW'(dir_idx);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_status_ff;

   `TLPT_ASSERT_NEXT(a_fire_to_busy, clock, reset, req_fire, state_ff == S_BUSY,
      "accepted request did not enter the busy state")
   `TLPT_ASSERT_NOW(a_no_rsp_in_clear, clock, reset, state_ff == S_CLEAR, !rsp_valid_ff,
      "response present during the clearing pass")
   `TLPT_ASSERT_NOW(a_page_absent_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff == ST_PAGE_ABSENT), rsp_word_ff == '0,
      "page-absent response carries a nonzero word")
   `TLPT_ASSERT_NOW(a_write_owner, clock, reset, tbl_we || dir_we,
      (state_ff == S_BUSY) || (state_ff == S_CLEAR),
      "RAM write outside busy or clearing state")

endmodule
